### rtl/assert_macros.svh
// assertion helpers included by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

### rtl/svn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package svn_pkg;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_FACE = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// fan vertex selectors for memory addressing
	localparam logic [1:0] SEL_ORG = 2'd0;
	localparam logic [1:0] SEL_PRV = 2'd1;
	localparam logic [1:0] SEL_CUR = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POS_RD0,
		ST_POS_RD1,
		ST_POS_RD2,
		ST_POS_CAP,
		ST_EDGE,
		ST_CROSS,
		ST_SUM_RD,
		ST_SUM_LD,
		ST_FIT,
		ST_SQ,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load_wr;
		logic       sum_clr;
		logic       pos_rd;
		logic [1:0] pos_sel;
		logic       edge_calc;
		logic       cross_calc;
		logic       nrm_from_sum;
		logic       nrm_fit;
		logic       nrm_sq;
		logic       sqrt_start;
		logic       div_start;
		logic [1:0] sum_sel;
		logic       sum_wr;
		logic       out_load;
		logic       out_clear;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic sqrt_done;
		logic div_done;
		logic len_zero;
	} status_t;

endpackage
`default_nettype wire

### rtl/svn_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// bit-serial integer square root, one result bit per cycle
module svn_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [62:0] radicand,
	output logic [31:0]      root,
	output logic             done
);
	logic [63:0] rem_q;
	logic [31:0] res_q;
	logic [63:0] v_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [65:0] trial;
	logic [65:0] remn;

	always_comb begin
		remn  = {rem_q, v_q[63:62]};
		trial = remn - {32'd0, res_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			res_q <= '0;
			v_q   <= {1'b0, radicand};
		end else if (busy_q) begin
			v_q <= {v_q[61:0], 2'b00};
			if (!trial[65]) begin
				rem_q <= trial[63:0];
				res_q <= {res_q[30:0], 1'b1};
			end else begin
				rem_q <= remn[63:0];
				res_q <= {res_q[30:0], 1'b0};
			end
		end
	end

	assign root = res_q;
endmodule
`default_nettype wire

### rtl/svn_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle, three lanes share the divisor
module svn_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [45:0] num_x,
	input  wire logic [45:0] num_y,
	input  wire logic [45:0] num_z,
	input  wire logic [32:0] den,
	output logic [15:0]      q_x,
	output logic [15:0]      q_y,
	output logic [15:0]      q_z,
	output logic             done
);
	// for a nonzero den the quotient never exceeds 16384, 16 bits suffice; remainder below den
	logic [45:0] n_q [3];
	logic [33:0] r_q [3];
	logic [15:0] qq  [3];
	logic [32:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] sh  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) sh[i] = {r_q[i][32:0], n_q[i][45]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd45) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q[0] <= num_x;
			n_q[1] <= num_y;
			n_q[2] <= num_z;
			for (int i = 0; i < 3; i++) begin
				r_q[i] <= '0;
				qq[i]  <= '0;
			end
			d_q <= den;
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				n_q[i] <= {n_q[i][44:0], 1'b0};
				if (sh[i] >= {1'b0, d_q}) begin
					r_q[i] <= sh[i] - {1'b0, d_q};
					qq[i]  <= {qq[i][14:0], 1'b1};
				end else begin
					r_q[i] <= sh[i];
					qq[i]  <= {qq[i][14:0], 1'b0};
				end
			end
		end
	end

	assign q_x = qq[0];
	assign q_y = qq[1];
	assign q_z = qq[2];
endmodule
`default_nettype wire

### rtl/svn_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module svn_datapath #(
	parameter int VERTS = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire svn_pkg::cmd_t            cmd,
	output svn_pkg::status_t              sts,
	input  wire logic [$clog2(VERTS)-1:0] load_addr,
	input  wire logic [31:0]              load_x,
	input  wire logic [31:0]              load_y,
	input  wire logic [31:0]              load_z,
	input  wire logic [$clog2(VERTS)-1:0] addr_a,
	input  wire logic [$clog2(VERTS)-1:0] addr_b,
	input  wire logic [$clog2(VERTS)-1:0] addr_c,
	output logic signed [15:0]            nx,
	output logic signed [15:0]            ny,
	output logic signed [15:0]            nz,
	output logic                          zflag
);
	localparam int AW = $clog2(VERTS);

	logic [95:0] pos_mem [VERTS];
	logic [95:0] sum_mem [VERTS];
	logic [95:0] pos_rd_q;
	logic [95:0] sum_rd_q;
	logic [AW-1:0] paddr;
	logic [AW-1:0] saddr;
	logic [AW-1:0] clr_q;

	logic signed [31:0] p_s1 [3][3];
	logic signed [32:0] e_q [6];
	logic signed [63:0] v_q [3];
	logic signed [30:0] f_q [3];
	logic [62:0] sq_q;
	logic [31:0] len_q;
	logic signed [15:0] tri_q [3];
	logic [1:0] pcnt_q;
	logic clr_done, sqrt_done, div_done, len_zero;

	assign sts = '{clr_done: clr_done, sqrt_done: sqrt_done, div_done: div_done,
		len_zero: len_zero};

	always_comb begin
		case (cmd.pos_sel)
			svn_pkg::SEL_ORG: paddr = addr_a;
			svn_pkg::SEL_PRV: paddr = addr_b;
			default:          paddr = addr_c;
		endcase
		case (cmd.sum_sel)
			svn_pkg::SEL_ORG: saddr = addr_a;
			svn_pkg::SEL_PRV: saddr = addr_b;
			default:          saddr = addr_c;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) pos_mem[load_addr] <= {load_z, load_y, load_x};
		pos_rd_q <= pos_mem[paddr];
	end

	// sums: load clears; add with saturation
	logic [95:0] sum_new;
	always_comb begin
		logic signed [32:0] t;
		sum_new = '0;
		for (int i = 0; i < 3; i++) begin
			t = 33'(signed'(sum_rd_q[i*32 +: 32])) + 33'(tri_q[i]);
			if (t > 33'sh07FFFFFFF)      sum_new[i*32 +: 32] = 32'h7FFFFFFF;
			else if (t < -33'sh080000000) sum_new[i*32 +: 32] = 32'h80000000;
			else                          sum_new[i*32 +: 32] = t[31:0];
		end
	end

	// clearing pass over the sum memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          clr_q <= '0;
		else if (cmd.sum_clr) clr_q <= clr_q + AW'(1);
	end
	assign clr_done = (clr_q == AW'(VERTS - 1));

	always_ff @(posedge clk) begin
		if (cmd.sum_clr)      sum_mem[clr_q] <= '0;
		else if (cmd.load_wr) sum_mem[load_addr] <= '0;
		else if (cmd.sum_wr)  sum_mem[saddr] <= sum_new;
		sum_rd_q <= sum_mem[saddr];
	end

	// position capture in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pcnt_q <= '0;
		else         pcnt_q <= cmd.pos_rd ? cmd.pos_sel : pcnt_q;
	end
	logic prd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prd_q <= 1'b0;
		else         prd_q <= cmd.pos_rd;
	end
	always_ff @(posedge clk) begin
		if (prd_q) begin
			for (int i = 0; i < 3; i++) p_s1[pcnt_q][i] <= signed'(pos_rd_q[i*32 +: 32]);
		end
	end

	// edges with common fit shift
	logic signed [32:0] er [6];
	logic [32:0] emax;
	logic [1:0] esh;
	always_comb begin
		emax = '0;
		for (int i = 0; i < 3; i++) begin
			er[i]   = 33'(p_s1[1][i]) - 33'(p_s1[0][i]);
			er[i+3] = 33'(p_s1[2][i]) - 33'(p_s1[0][i]);
		end
		for (int i = 0; i < 6; i++) begin
			emax = emax | (er[i][32] ? 33'(-er[i]) : 33'(er[i]));
		end
		if (emax[32])      esh = 2'd3;
		else if (emax[31]) esh = 2'd2;
		else if (emax[30]) esh = 2'd1;
		else               esh = 2'd0;
	end

	// fit helper for 64-bit vectors
	function automatic logic [5:0] fit64(input logic signed [63:0] a, input logic signed [63:0] b,
		input logic signed [63:0] c);
		logic [63:0] m;
		logic [5:0] s;
		m = (a[63] ? 64'(-a) : 64'(a)) | (b[63] ? 64'(-b) : 64'(b)) |
			(c[63] ? 64'(-c) : 64'(c));
		s = 6'd0;
		for (int k = 30; k < 64; k++) if (m[k]) s = 6'(k - 29);
		return s;
	endfunction

	logic [5:0] vsh;
	always_comb vsh = fit64(v_q[0], v_q[1], v_q[2]);

	always_ff @(posedge clk) begin
		if (cmd.edge_calc) begin
			for (int i = 0; i < 6; i++) e_q[i] <= er[i] >>> esh;
		end
		if (cmd.cross_calc) begin
			v_q[0] <= 64'(e_q[1]) * 64'(e_q[5]) - 64'(e_q[2]) * 64'(e_q[4]);
			v_q[1] <= 64'(e_q[2]) * 64'(e_q[3]) - 64'(e_q[0]) * 64'(e_q[5]);
			v_q[2] <= 64'(e_q[0]) * 64'(e_q[4]) - 64'(e_q[1]) * 64'(e_q[3]);
		end else if (cmd.nrm_from_sum) begin
			for (int i = 0; i < 3; i++) v_q[i] <= 64'(signed'(sum_rd_q[i*32 +: 32]));
		end
		if (cmd.nrm_fit) begin
			for (int i = 0; i < 3; i++) f_q[i] <= 31'(v_q[i] >>> vsh);
		end
		if (cmd.nrm_sq) begin
			sq_q <= 63'(f_q[0]) * 63'(f_q[0]) + 63'(f_q[1]) * 63'(f_q[1]) +
				63'(f_q[2]) * 63'(f_q[2]);
		end
	end

	// square root and division units
	logic [31:0] root;
	svn_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start),
		.radicand(sq_q), .root(root), .done(sqrt_done)
	);
	always_ff @(posedge clk) if (sqrt_done) len_q <= root;
	assign len_zero = (len_q == '0);

	logic [30:0] mag [3];
	logic [45:0] num [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = f_q[i][30] ? 31'(-f_q[i]) : 31'(f_q[i]);
			num[i] = {mag[i], 15'd0} + 46'(len_q);
		end
	end
	logic [15:0] qx, qy, qz;
	svn_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num_x(num[0]), .num_y(num[1]), .num_z(num[2]),
		.den({len_q, 1'b0}), .q_x(qx), .q_y(qy), .q_z(qz), .done(div_done)
	);
	logic signed [15:0] sx, sy, sz;
	always_comb begin
		sx = f_q[0][30] ? -signed'(qx) : signed'(qx);
		sy = f_q[1][30] ? -signed'(qy) : signed'(qy);
		sz = f_q[2][30] ? -signed'(qz) : signed'(qz);
	end
	always_ff @(posedge clk) begin
		if (div_done) begin
			tri_q[0] <= len_zero ? 16'sd0 : sx;
			tri_q[1] <= len_zero ? 16'sd0 : sy;
			tri_q[2] <= len_zero ? 16'sd0 : sz;
		end
		if (cmd.out_clear) begin
			nx <= '0; ny <= '0; nz <= '0; zflag <= 1'b1;
		end else if (cmd.out_load) begin
			nx <= len_zero ? 16'sd0 : sx;
			ny <= len_zero ? 16'sd0 : sy;
			nz <= len_zero ? 16'sd0 : sz;
			zflag <= len_zero;
		end
	end
endmodule
`default_nettype wire

### rtl/svn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module svn_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_acc,
	input  wire logic [1:0]       req,
	input  wire logic             idx_ok,
	input  wire logic             tri_go,
	input  wire svn_pkg::status_t sts,
	input  wire logic             out_stall,
	output logic                  in_stall,
	output logic                  out_valid,
	output logic                  fan_upd,
	output logic                  fan_adv,
	output svn_pkg::cmd_t         cmd
);
	svn_pkg::state_t st_q, st_d;
	logic from_read_q, from_read_d;
	logic [1:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= svn_pkg::ST_CLEAR;
			from_read_q <= 1'b0;
			k_q <= '0;
		end else begin
			st_q <= st_d;
			from_read_q <= from_read_d;
			k_q <= k_d;
		end
	end

	assign in_stall = (st_q != svn_pkg::ST_IDLE);

	always_comb begin
		st_d = st_q;
		from_read_d = from_read_q;
		k_d = k_q;
		cmd = '0;
		out_valid = 1'b0;
		fan_upd = 1'b0;
		fan_adv = 1'b0;
		case (st_q)
			svn_pkg::ST_CLEAR: begin
				cmd.sum_clr = 1'b1;
				if (sts.clr_done) st_d = svn_pkg::ST_IDLE;
			end
			svn_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (req)
						svn_pkg::REQ_LOAD: cmd.load_wr = idx_ok;
						svn_pkg::REQ_FACE: begin
							fan_upd = idx_ok;
							if (idx_ok && tri_go) begin
								from_read_d = 1'b0;
								st_d = svn_pkg::ST_POS_RD0;
							end
						end
						svn_pkg::REQ_READ: begin
							if (idx_ok) begin
								from_read_d = 1'b1;
								st_d = svn_pkg::ST_SUM_RD;
							end else begin
								cmd.out_clear = 1'b1;
								st_d = svn_pkg::ST_OUT;
							end
						end
						default: ;
					endcase
				end
			end
			svn_pkg::ST_POS_RD0: begin
				cmd.pos_rd = 1'b1; cmd.pos_sel = svn_pkg::SEL_ORG; st_d = svn_pkg::ST_POS_RD1;
			end
			svn_pkg::ST_POS_RD1: begin
				cmd.pos_rd = 1'b1; cmd.pos_sel = svn_pkg::SEL_PRV; st_d = svn_pkg::ST_POS_RD2;
			end
			svn_pkg::ST_POS_RD2: begin
				cmd.pos_rd = 1'b1; cmd.pos_sel = svn_pkg::SEL_CUR; st_d = svn_pkg::ST_POS_CAP;
			end
			svn_pkg::ST_POS_CAP: st_d = svn_pkg::ST_EDGE;
			svn_pkg::ST_EDGE: begin
				cmd.edge_calc = 1'b1; st_d = svn_pkg::ST_CROSS;
			end
			svn_pkg::ST_CROSS: begin
				cmd.cross_calc = 1'b1; st_d = svn_pkg::ST_FIT;
			end
			svn_pkg::ST_SUM_RD: begin
				cmd.sum_sel = svn_pkg::SEL_CUR; st_d = svn_pkg::ST_SUM_LD;
			end
			svn_pkg::ST_SUM_LD: begin
				cmd.nrm_from_sum = 1'b1; st_d = svn_pkg::ST_FIT;
			end
			svn_pkg::ST_FIT: begin
				cmd.nrm_fit = 1'b1; st_d = svn_pkg::ST_SQ;
			end
			svn_pkg::ST_SQ: begin
				cmd.nrm_sq = 1'b1; st_d = svn_pkg::ST_SQRT_GO;
			end
			svn_pkg::ST_SQRT_GO: begin
				cmd.sqrt_start = 1'b1; st_d = svn_pkg::ST_SQRT_WAIT;
			end
			svn_pkg::ST_SQRT_WAIT: begin
				if (sts.sqrt_done) st_d = svn_pkg::ST_DIV_GO;
			end
			svn_pkg::ST_DIV_GO: begin
				cmd.div_start = 1'b1; st_d = svn_pkg::ST_DIV_WAIT;
			end
			svn_pkg::ST_DIV_WAIT: begin
				if (sts.div_done) begin
					if (from_read_q) begin
						cmd.out_load = 1'b1;
						st_d = svn_pkg::ST_OUT;
					end else begin
						k_d = 2'd0;
						st_d = svn_pkg::ST_ACC_RD;
					end
				end
			end
			// k walks origin, previous, current
			svn_pkg::ST_ACC_RD: begin
				cmd.sum_sel = k_q; st_d = svn_pkg::ST_ACC_WR;
			end
			svn_pkg::ST_ACC_WR: begin
				cmd.sum_sel = k_q;
				cmd.sum_wr = 1'b1;
				if (k_q == svn_pkg::SEL_CUR) begin
					fan_adv = 1'b1;
					st_d = svn_pkg::ST_IDLE;
				end else begin
					k_d = k_q + 2'd1;
					st_d = svn_pkg::ST_ACC_RD;
				end
			end
			svn_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) st_d = svn_pkg::ST_IDLE;
			end
			default: st_d = svn_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/smooth_vertex_normals_unit.sv
// smooth vertex normal generator
// input channel: in_valid / in_stall carries one word per request:
//   req_type 0 loads a position and clears its normal sum, 1 is a face
//   vertex (face_start on the first vertex of each face), 2 reads a normal
// output channel: out_valid / out_stall carries one word per read request
// loads, fan setup vertices and ignored words are taken every cycle while idle
// a triangle-forming face vertex holds in_stall through three position reads,
//   edge and cross product, fit and sum of squares, a 32-step square root,
//   a 46-step divide and three read-modify-write updates of the normal sum
//   memory
// a read passes through the sum read, fit, square, root and divide steps before
//   out_valid rises; a read of an index of VERTS or more answers in the next cycle
// one request is processed at a time; in_stall is high while busy
// when out_stall is high the result word holds and no new request is taken
// after reset a clearing pass zeroes the normal sums while holding in_stall;
//   the fan state and controller start cleared
`timescale 1ns / 1ps
`default_nettype none
module smooth_vertex_normals_unit #(
	parameter int VERTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [9:0]         vertex_index,
	input  wire logic               face_start,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [9:0]              out_index,
	output logic signed [15:0]      norm_x,
	output logic signed [15:0]      norm_y,
	output logic signed [15:0]      norm_z,
	output logic                    zero_sum
);
	localparam int AW = $clog2(VERTS);

	svn_pkg::cmd_t    cmd;
	svn_pkg::status_t sts;
	logic in_acc, idx_ok, tri_go, fan_upd, fan_adv;
	logic [AW-1:0] org_q, prv_q, cur_q;
	logic [1:0] cnt_q;

	assign in_acc = in_valid && !in_stall;
	assign idx_ok = 32'(vertex_index) < VERTS;
	assign tri_go = (cnt_q >= 2'd2) && !face_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '0; prv_q <= '0; cur_q <= '0; cnt_q <= '0; out_index <= '0;
		end else begin
			if (in_acc) begin
				out_index <= vertex_index;
				cur_q <= AW'(vertex_index);
				if (fan_upd) begin
					if (face_start) begin
						org_q <= AW'(vertex_index); cnt_q <= 2'd1;
					end else if (cnt_q == 2'd1) begin
						prv_q <= AW'(vertex_index); cnt_q <= 2'd2;
					end
				end
			end
			if (fan_adv) begin
				prv_q <= cur_q; cnt_q <= 2'd3;
			end
		end
	end

	svn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_acc(in_acc), .req(req_type), .idx_ok(idx_ok),
		.tri_go(tri_go), .sts(sts), .out_stall(out_stall), .in_stall(in_stall),
		.out_valid(out_valid), .fan_upd(fan_upd), .fan_adv(fan_adv), .cmd(cmd)
	);

	svn_datapath #(.VERTS(VERTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.load_addr(AW'(vertex_index)), .load_x(pos_x), .load_y(pos_y), .load_z(pos_z),
		.addr_a(org_q), .addr_b(prv_q), .addr_c(cur_q),
		.nx(norm_x), .ny(norm_y), .nz(norm_z), .zflag(zero_sum)
	);
endmodule
`default_nettype wire

### rtl/svn_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module svn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [9:0]  out_index,
	input wire logic        zero_sum,
	input wire logic [15:0] norm_x
);
	`ASSERT_IMPLIES(a_out_hold, clk, arst_n, out_valid && out_stall, ##1 out_valid, "out dropped")
	`ASSERT_IMPLIES(a_idx_hold, clk, arst_n, out_valid && out_stall, ##1 $stable(out_index), "index moved")
	`ASSERT_IMPLIES(a_busy, clk, arst_n, out_valid, in_stall, "input taken while result pending")
	`ASSERT_IMPLIES(a_zero, clk, arst_n, out_valid && zero_sum, norm_x == 16'd0, "zero flag with nonzero x")
endmodule
bind smooth_vertex_normals_unit svn_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_index(out_index),
	.zero_sum(zero_sum), .norm_x(norm_x)
);
`default_nettype wire

### dv/tb_smooth_vertex_normals_unit.sv
`timescale 1ns / 1ps

class normal_scoreboard;
	typedef struct {
		logic [9:0]  idx;
		logic [15:0] nx, ny, nz;
		logic        zs;
	} normal_word_t;

	int pos [1024][3];
	int acc [1024][3];
	logic [9:0] fan_org, fan_prv;
	int fan_cnt;
	normal_word_t pending_q[$];
	int errors;

	function new();
		for (int v = 0; v < 1024; v++)
			for (int a = 0; a < 3; a++) begin
				pos[v][a] = 0;
				acc[v][a] = 0;
			end
		fan_org = 0;
		fan_prv = 0;
		fan_cnt = 0;
		errors = 0;
	endfunction

	function longint unsigned mag(longint v);
		return v >= 0 ? v : -v;
	endfunction

	function int fit(longint v[6], int n);
		longint unsigned m;
		int s;
		m = 0;
		s = 0;
		for (int i = 0; i < n; i++)
			if (mag(v[i]) > m) m = mag(v[i]);
		while ((m >> s) >= 64'd1073741824) s++;
		return s;
	endfunction

	function longint unsigned root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function bit unit_q14(longint vin[3], output int o[3]);
		longint w[6];
		longint unsigned sq, len, q;
		int s;
		for (int i = 0; i < 6; i++) w[i] = i < 3 ? vin[i] : 0;
		s = fit(w, 3);
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			w[i] = w[i] >>> s;
			sq += mag(w[i]) * mag(w[i]);
		end
		len = root(sq);
		o[0] = 0;
		o[1] = 0;
		o[2] = 0;
		if (len == 0) return 0;
		for (int i = 0; i < 3; i++) begin
			q = (mag(w[i]) * 32768 + len) / (2 * len);
			o[i] = w[i] < 0 ? -int'(q) : int'(q);
		end
		return 1;
	endfunction

	function void add_triangle(logic [9:0] a, logic [9:0] b, logic [9:0] c);
		longint e[6], cr[3], t;
		int n[3], s;
		bit nz;
		logic [9:0] vs[3];
		for (int i = 0; i < 3; i++) begin
			e[i] = longint'(pos[b][i]) - longint'(pos[a][i]);
			e[i + 3] = longint'(pos[c][i]) - longint'(pos[a][i]);
		end
		s = fit(e, 6);
		for (int i = 0; i < 6; i++) e[i] = e[i] >>> s;
		cr[0] = e[1] * e[5] - e[2] * e[4];
		cr[1] = e[2] * e[3] - e[0] * e[5];
		cr[2] = e[0] * e[4] - e[1] * e[3];
		nz = unit_q14(cr, n);
		vs[0] = a;
		vs[1] = b;
		vs[2] = c;
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++) begin
				t = longint'(acc[vs[k]][i]) + n[i];
				if (t > 64'sd2147483647) t = 64'sd2147483647;
				if (t < -64'sd2147483648) t = -64'sd2147483648;
				acc[vs[k]][i] = int'(t);
			end
	endfunction

	function void note_input(logic [1:0] kind, logic [9:0] idx, logic st,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		normal_word_t w;
		longint v[3];
		int n[3];
		bit nz;
		case (kind)
			svn_pkg::REQ_LOAD: begin
				pos[idx][0] = x;
				pos[idx][1] = y;
				pos[idx][2] = z;
				acc[idx][0] = 0;
				acc[idx][1] = 0;
				acc[idx][2] = 0;
			end
			svn_pkg::REQ_FACE: begin
				if (st) begin
					fan_org = idx;
					fan_cnt = 1;
				end else if (fan_cnt == 1) begin
					fan_prv = idx;
					fan_cnt = 2;
				end else if (fan_cnt >= 2) begin
					add_triangle(fan_org, fan_prv, idx);
					fan_prv = idx;
					fan_cnt = 3;
				end
			end
			svn_pkg::REQ_READ: begin
				for (int i = 0; i < 3; i++) v[i] = acc[idx][i];
				nz = unit_q14(v, n);
				w.idx = idx;
				w.nx = 16'(n[0]);
				w.ny = 16'(n[1]);
				w.nz = 16'(n[2]);
				w.zs = !nz;
				pending_q.push_back(w);
			end
			default: ;
		endcase
	endfunction

	function void check_result(logic [9:0] idx, logic [15:0] nx, logic [15:0] ny,
			logic [15:0] nz, logic zs);
		normal_word_t w;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected normal word, index %0d", $time, idx);
			errors++;
			return;
		end
		w = pending_q.pop_front();
		if (idx !== w.idx) begin
			$display("%0t: out_index expected %0d actual %0d", $time, w.idx, idx);
			errors++;
		end
		if (nx !== w.nx) begin
			$display("%0t: norm_x expected %h actual %h", $time, w.nx, nx);
			errors++;
		end
		if (ny !== w.ny) begin
			$display("%0t: norm_y expected %h actual %h", $time, w.ny, ny);
			errors++;
		end
		if (nz !== w.nz) begin
			$display("%0t: norm_z expected %h actual %h", $time, w.nz, nz);
			errors++;
		end
		if (zs !== w.zs) begin
			$display("%0t: zero_sum expected %b actual %b", $time, w.zs, zs);
			errors++;
		end
	endfunction
endclass

module tb_smooth_vertex_normals_unit;
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] req_type = 0;
	logic [9:0] vertex_index = 0;
	logic face_start = 0;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [9:0] out_index;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic zero_sum;

	normal_scoreboard sb = new();
	int cycles = 0;
	int burst_left = 0;
	int sent = 0;
	int stall_mode = 0;
	int stall_cnt = 0;
	logic [9:0] loaded_q[$];
	bit is_loaded [1024];

	smooth_vertex_normals_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .vertex_index(vertex_index), .face_start(face_start),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_index(out_index), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.zero_sum(zero_sum)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_smooth_vertex_normals_unit: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_index, norm_x, norm_y, norm_z, zero_sum);
	end

	// receiver stall pattern in one of four modes, redrawn at random
	always @(negedge clk) begin
		stall_cnt++;
		if (stall_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall = 0;
			1: out_stall = 1'($urandom_range(0, 1));
			2: out_stall = ($urandom_range(0, 7) != 0);
			default: out_stall = ((stall_cnt / 13) % 2 == 1);
		endcase
	end

	task automatic send_word(logic [1:0] kind, logic [9:0] idx, logic st,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		in_valid = 1;
		req_type = kind;
		vertex_index = idx;
		face_start = st;
		pos_x = x;
		pos_y = y;
		pos_z = z;
		do @(posedge clk); while (in_stall);
		sb.note_input(kind, idx, st, x, y, z);
		if (kind == svn_pkg::REQ_LOAD) begin
			if (!is_loaded[idx]) loaded_q.push_back(idx);
			is_loaded[idx] = 1;
		end
		sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid = 0;
				req_type = 2'($urandom);
				vertex_index = 10'($urandom);
				face_start = 1'($urandom);
				pos_x = $urandom;
				pos_y = $urandom;
				pos_z = $urandom;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 6);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		endcase
	endfunction

	task automatic load_vertex(logic [9:0] idx);
		send_word(svn_pkg::REQ_LOAD, idx, 0, rand_coord(), rand_coord(), rand_coord());
	endtask

	function automatic logic [9:0] pick_loaded();
		return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
	endfunction

	logic [9:0] pool[64];
	int n_face;

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// face vertex before any start, unused request, read of empty sum
		send_word(svn_pkg::REQ_FACE, 0, 0, 0, 0, 0);
		send_word(REQ_NONE, 7, 1, 0, 0, 0);
		send_word(svn_pkg::REQ_READ, 5, 0, 0, 0, 0);
		send_word(svn_pkg::REQ_LOAD, 0, 0, 0, 0, 0);
		send_word(svn_pkg::REQ_LOAD, 1, 0, 32'h7fffffff, 0, 0);
		send_word(svn_pkg::REQ_LOAD, 2, 0, 0, 32'h7fffffff, 0);
		send_word(svn_pkg::REQ_LOAD, 3, 0, 32'h80000000, 32'h80000000, 32'h7fffffff);
		send_word(svn_pkg::REQ_LOAD, 4, 0, 1, 0, 0);
		send_word(svn_pkg::REQ_LOAD, 5, 0, 0, 1, 0);
		send_word(svn_pkg::REQ_FACE, 0, 1, 0, 0, 0);
		send_word(svn_pkg::REQ_FACE, 1, 0, 0, 0, 0);
		send_word(svn_pkg::REQ_FACE, 2, 0, 0, 0, 0);
		send_word(svn_pkg::REQ_FACE, 3, 0, 0, 0, 0);
		send_word(svn_pkg::REQ_FACE, 4, 0, 0, 0, 0);
		// repeated vertex gives a degenerate triangle
		send_word(svn_pkg::REQ_FACE, 4, 1, 0, 0, 0);
		send_word(svn_pkg::REQ_FACE, 4, 0, 0, 0, 0);
		send_word(svn_pkg::REQ_FACE, 4, 0, 0, 0, 0);
		send_word(svn_pkg::REQ_FACE, 0, 1, 0, 0, 0);
		send_word(svn_pkg::REQ_FACE, 4, 0, 0, 0, 0);
		send_word(svn_pkg::REQ_FACE, 5, 0, 0, 0, 0);
		for (int i = 0; i < 5; i++) send_word(svn_pkg::REQ_READ, 10'(i), 0, 0, 0, 0);
		send_word(svn_pkg::REQ_READ, 1023, 0, 0, 0, 0);
		send_word(svn_pkg::REQ_LOAD, 0, 0, 32'hffffffff, 32'h00010000, 32'h7fffffff);
		send_word(svn_pkg::REQ_READ, 0, 0, 0, 0, 0);

		for (int i = 0; i < 64; i++) pool[i] = 10'($urandom);
		while (sent < 1900) begin
			case ($urandom_range(0, 19))
				0, 1, 2: load_vertex(pool[$urandom_range(0, 63)]);
				3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
					if (loaded_q.size() == 0) load_vertex(pool[$urandom_range(0, 63)]);
					n_face = $urandom_range(3, 6);
					for (int k = 0; k < n_face; k++)
						send_word(svn_pkg::REQ_FACE, pick_loaded(), k == 0, $urandom,
							$urandom, $urandom);
				end
				13, 14, 15: send_word(svn_pkg::REQ_READ, ($urandom_range(0, 3) == 0)
					? 10'($urandom) : pool[$urandom_range(0, 63)], 1'($urandom),
					$urandom, $urandom, $urandom);
				16: send_word(REQ_NONE, 10'($urandom), 1'($urandom), $urandom, $urandom,
					$urandom);
				default: begin
					if (loaded_q.size() == 0) load_vertex(pool[$urandom_range(0, 63)]);
					send_word(svn_pkg::REQ_FACE, pick_loaded(), 1'($urandom_range(0, 1)),
						$urandom, $urandom, $urandom);
				end
			endcase
		end

		in_valid = 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_smooth_vertex_normals_unit: clean");
		else
			$display("tb_smooth_vertex_normals_unit: errors");
		$finish;
	end
endmodule
